// ----- rtl/core/shdg_pkg.sv -----
// shared types and codes for the sorted hash duplicate grouper
package shdg_pkg;

	localparam int HASH_W      = 64;
	localparam int ID_W        = 16;
	localparam int CNT_MAX_W   = 13;
	localparam int MAX_RESULTS = 64;
	localparam int NOUT_W      = 7;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_LIST  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_MISSING = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_GROUP   = 3'd3;
	localparam logic [2:0] ST_MATCH   = 3'd4;
	localparam logic [2:0] ST_NONE    = 3'd5;

	localparam logic [1:0] OP_RESULT = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_LIST   = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [HASH_W-1:0] hash_value;
		logic              hash_present;
	} req_item_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] entry_id;
		logic            group_start;
		logic            last;
	} rsp_item_t;

	typedef struct packed {
		logic [1:0]           op;
		logic [2:0]           status;
		logic [HASH_W-1:0]    hash;
		logic [ID_W-1:0]      id;
		logic [CNT_MAX_W-1:0] cnt;
	} cmd_t;

endpackage

// ----- rtl/core/shdg_front.sv -----
// request decode: id counter, entry count mirror and command build
module shdg_front #(
	parameter int MAX_ENTRIES = 64,
	parameter int ID_BITS     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  shdg_pkg::req_item_t req_item,
	output logic              push,
	output shdg_pkg::cmd_t    cmd,
	input  logic              fifo_full
);
	import shdg_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	logic [ID_BITS-1:0] next_id_q;
	logic [CNT_W-1:0]   count_q;
	logic               accept;
	logic               is_add;
	logic               do_insert;

	assign req_stall = fifo_full;
	assign accept    = req_valid && !fifo_full;
	assign is_add    = req_item.req_type == REQ_ADD;
	assign do_insert = is_add && req_item.hash_present && (count_q != CNT_W'(MAX_ENTRIES));
	assign push      = accept && (req_item.req_type == REQ_ADD || req_item.req_type == REQ_LIST ||
		req_item.req_type == REQ_QUERY);

	always_comb begin
		cmd        = '0;
		cmd.hash   = req_item.hash_value;
		cmd.cnt    = CNT_MAX_W'(count_q);
		cmd.id     = ID_W'(next_id_q);
		cmd.op     = OP_RESULT;
		cmd.status = ST_NONE;
		case (req_item.req_type)
			REQ_ADD: begin
				if (!req_item.hash_present) begin
					cmd.status = ST_MISSING;
				end else if (!do_insert) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.op     = OP_INSERT;
					cmd.status = ST_ADDED;
				end
			end
			REQ_LIST: begin
				cmd.op = OP_LIST;
			end
			REQ_QUERY: begin
				if (req_item.hash_present) begin
					cmd.op = OP_QUERY;
				end else begin
					cmd.id = '0;
				end
			end
			default: begin
				cmd.op = OP_RESULT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= '0;
			count_q   <= '0;
		end else if (accept && is_add) begin
			// id is consumed even when nothing is stored; counter saturates
			if (next_id_q != '1) begin
				next_id_q <= next_id_q + ID_BITS'(1);
			end
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/shdg_cmd_fifo.sv -----
// two-entry command queue between decode and table engine
module shdg_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  shdg_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output shdg_pkg::cmd_t rdata,
	output logic           empty
);
	import shdg_pkg::*;

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;

	assign full  = fill_q == 2'd2;
	assign empty = fill_q == 2'd0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wptr_q <= !wptr_q;
			end
			if (pop && !empty) begin
				rptr_q <= !rptr_q;
			end
			fill_q <= fill_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

// ----- rtl/core/shdg_engine.sv -----
// sorted table memory with insertion, group listing and query scans
module shdg_engine #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_empty,
	input  shdg_pkg::cmd_t      cmd,
	output logic                pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output shdg_pkg::rsp_item_t rsp_item
);
	import shdg_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W = $clog2(MAX_ENTRIES);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_RES      = 4'd1;
	localparam logic [3:0] S_INS_EMIT = 4'd2;
	localparam logic [3:0] S_INS_RD   = 4'd3;
	localparam logic [3:0] S_INS_CMP  = 4'd4;
	localparam logic [3:0] S_INS_PUT  = 4'd5;
	localparam logic [3:0] S_SCAN_RD  = 4'd6;
	localparam logic [3:0] S_SCAN_CMP = 4'd7;
	localparam logic [3:0] S_END      = 4'd8;
	localparam logic [3:0] S_FLUSH    = 4'd9;

	logic [HASH_W-1:0] mem_hash [MAX_ENTRIES];
	logic [ID_W-1:0]   mem_id   [MAX_ENTRIES];

	logic [3:0]        state_q;
	cmd_t              cmd_q;
	logic [CNT_W-1:0]  idx_q;
	logic [HASH_W-1:0] rd_hash_q;
	logic [ID_W-1:0]   rd_id_q;
	logic [HASH_W-1:0] prev_hash_q;
	logic [ID_W-1:0]   prev_id_q;
	logic              have_prev_q;
	logic              in_run_q;
	logic              pend_valid_q;
	rsp_item_t         pend_q;
	logic [NOUT_W-1:0] nout_q;
	logic              out_valid_q;
	rsp_item_t         out_q;

	logic              out_free;
	logic [CNT_W-1:0]  cnt;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [HASH_W-1:0] whash;
	logic [ID_W-1:0]   wid;
	logic              eq_cmd;
	logic              eq_prev;
	logic              gen;
	rsp_item_t         gen_item;
	logic              can_gen;
	logic              emit;
	rsp_item_t         emit_item;
	logic              last_gen;
	logic              scan_done;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign cnt       = CNT_W'(cmd_q.cnt);
	assign eq_cmd    = rd_hash_q == cmd_q.hash;
	assign eq_prev   = rd_hash_q == prev_hash_q;
	assign can_gen   = !pend_valid_q || out_free;
	assign last_gen  = nout_q == NOUT_W'(MAX_RESULTS - 1);
	assign scan_done = (idx_q + CNT_W'(1)) == cnt;
	assign pop       = (state_q == S_IDLE) && !cmd_empty;
	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

	// read port
	always_comb begin
		rd_en   = (state_q == S_INS_RD) || (state_q == S_SCAN_RD);
		rd_addr = (state_q == S_INS_RD) ? ADDR_W'(idx_q - CNT_W'(1)) : ADDR_W'(idx_q);
	end

	// write port: shift an entry up or drop the new one in
	always_comb begin
		we    = 1'b0;
		waddr = ADDR_W'(idx_q);
		whash = cmd_q.hash;
		wid   = cmd_q.id;
		if (state_q == S_INS_CMP) begin
			we = 1'b1;
			if (rd_hash_q > cmd_q.hash) begin
				whash = rd_hash_q;
				wid   = rd_id_q;
			end
		end else if (state_q == S_INS_PUT) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_hash[waddr] <= whash;
			mem_id[waddr]   <= wid;
		end
		if (rd_en) begin
			rd_hash_q <= mem_hash[rd_addr];
			rd_id_q   <= mem_id[rd_addr];
		end
	end

	// scan result generation
	always_comb begin
		gen      = 1'b0;
		gen_item = '0;
		gen_item.last = 1'b0;
		if (state_q == S_SCAN_CMP) begin
			if (cmd_q.op == OP_QUERY) begin
				gen               = eq_cmd;
				gen_item.status   = ST_MATCH;
				gen_item.entry_id = rd_id_q;
			end else begin
				gen                  = have_prev_q && (eq_prev || in_run_q);
				gen_item.status      = ST_GROUP;
				gen_item.entry_id    = prev_id_q;
				gen_item.group_start = eq_prev && !in_run_q;
			end
		end else if (state_q == S_END) begin
			gen               = in_run_q;
			gen_item.status   = ST_GROUP;
			gen_item.entry_id = prev_id_q;
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		case (state_q)
			S_RES, S_INS_EMIT: begin
				emit               = out_free;
				emit_item.status   = cmd_q.status;
				emit_item.entry_id = cmd_q.id;
				emit_item.last     = 1'b1;
			end
			S_SCAN_CMP, S_END: begin
				emit           = gen && pend_valid_q && out_free;
				emit_item      = pend_q;
				emit_item.last = 1'b0;
			end
			S_FLUSH: begin
				emit = out_free;
				if (pend_valid_q) begin
					emit_item = pend_q;
				end else begin
					emit_item.status = ST_NONE;
				end
				emit_item.last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			idx_q        <= '0;
			prev_hash_q  <= '0;
			prev_id_q    <= '0;
			have_prev_q  <= 1'b0;
			in_run_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			nout_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						cmd_q        <= cmd;
						idx_q        <= CNT_W'(cmd.cnt);
						have_prev_q  <= 1'b0;
						in_run_q     <= 1'b0;
						pend_valid_q <= 1'b0;
						nout_q       <= '0;
						case (cmd.op)
							OP_RESULT: state_q <= S_RES;
							OP_INSERT: state_q <= S_INS_EMIT;
							default: begin
								idx_q   <= '0;
								state_q <= (cmd.cnt == '0) ? S_FLUSH : S_SCAN_RD;
							end
						endcase
					end
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_INS_EMIT: begin
					if (out_free) begin
						state_q <= (idx_q == '0) ? S_INS_PUT : S_INS_RD;
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (rd_hash_q > cmd_q.hash) begin
						idx_q   <= idx_q - CNT_W'(1);
						state_q <= (idx_q == CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_INS_PUT: begin
					state_q <= S_IDLE;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (!gen || can_gen) begin
						prev_hash_q <= rd_hash_q;
						prev_id_q   <= rd_id_q;
						have_prev_q <= 1'b1;
						in_run_q    <= have_prev_q && eq_prev;
						idx_q       <= idx_q + CNT_W'(1);
						if (gen) begin
							pend_q       <= gen_item;
							pend_valid_q <= 1'b1;
							nout_q       <= nout_q + NOUT_W'(1);
						end
						if (gen && last_gen) begin
							state_q <= S_FLUSH;
						end else if (scan_done) begin
							state_q <= (cmd_q.op == OP_LIST) ? S_END : S_FLUSH;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_END: begin
					if (!gen || can_gen) begin
						if (gen) begin
							pend_q       <= gen_item;
							pend_valid_q <= 1'b1;
						end
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/sorted_hash_duplicate_grouper.sv -----
// sorted hash duplicate grouper: a sorted (hash, id) table with add, group list and query
// add: the result is emitted first, then the insertion shifts each larger entry up one place
// list and query: one scan over the stored entries through the single table read port
// a decode front and a two-command queue accept new transactions while the table engine works
// reset clears the id counter, the entry count, the queue and the output; the table is not cleared
module sorted_hash_duplicate_grouper #(
	parameter int MAX_ENTRIES = 64,
	parameter int ID_BITS     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  shdg_pkg::req_item_t req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output shdg_pkg::rsp_item_t rsp_item
);
	import shdg_pkg::*;

	logic push;
	logic fifo_full;
	logic fifo_empty;
	logic pop;
	cmd_t cmd_in;
	cmd_t cmd_out;

	shdg_front #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.ID_BITS(ID_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.push(push),
		.cmd(cmd_in),
		.fifo_full(fifo_full)
	);

	shdg_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(cmd_in),
		.full(fifo_full),
		.pop(pop),
		.rdata(cmd_out),
		.empty(fifo_empty)
	);

	shdg_engine #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(fifo_empty),
		.cmd(cmd_out),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item)
	);

endmodule
